### rtl/rpp_pkg.sv
package rpp_pkg;

  localparam int CHAN_W     = 8;
  localparam int GAIN_W     = 16;
  localparam int OFFSET_W   = 17;
  localparam int FILL_W     = 8;
  localparam int SHADE_W    = 9;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int LIN_P_W  = GAIN_W + CHAN_W + 1;
  localparam int LIN_S_W  = LIN_P_W + 1;
  localparam int LUMA_P_W = 24;

  localparam int DIV_STEPS       = CHAN_W;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;
  localparam int PIPE_LATENCY    = 2 + 1 + DIV_STAGES + 1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;
  localparam logic [LUMA_P_W-1:0] LUMA_ROUND = 24'd32768;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUANT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHADES = 3'd4;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t              lin;
    logic [CHAN_W-1:0] luma;
  } side_t;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic signed [GAIN_W-1:0]   gain;
    logic signed [OFFSET_W-1:0] offset;
    logic [FILL_W-1:0]          fill_level;
    logic [SHADE_W-1:0]         shade_count;
  } cfg_t;

endpackage

### rtl/rpp_cfg.sv
module rpp_cfg import rpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   cfg_nxt.mode        = cfg_data[MODE_W-1:0];
        REG_GAIN:   cfg_nxt.gain        = $signed(cfg_data[GAIN_W-1:0]);
        REG_OFFSET: cfg_nxt.offset      = $signed(cfg_data[OFFSET_W-1:0]);
        REG_FILL:   cfg_nxt.fill_level  = cfg_data[FILL_W-1:0];
        REG_SHADES: cfg_nxt.shade_count = cfg_data[SHADE_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_LINEAR;
      cfg_r.gain        <= 16'sd256;
      cfg_r.offset      <= '0;
      cfg_r.fill_level  <= '0;
      cfg_r.shade_count <= 9'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/rpp_front.sv
module rpp_front import rpp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  pix_t                       in_pix,
  input  logic signed [GAIN_W-1:0]   gain,
  input  logic signed [OFFSET_W-1:0] offset,
  output logic                       out_valid,
  output side_t                      out_side
);

  logic                       v1_r;
  logic signed [LIN_P_W-1:0]  linp_r  [3];
  logic signed [LIN_P_W-1:0]  linp_nxt[3];
  logic [LUMA_P_W-1:0]        lump_r  [3];
  logic [LUMA_P_W-1:0]        lump_nxt[3];
  logic [CHAN_W-1:0]          chan    [3];
  logic                       v2_r;
  side_t                      side_r;
  side_t                      side_nxt;
  logic [CHAN_W-1:0]          lin_val [3];

  assign chan[0] = in_pix.red;
  assign chan[1] = in_pix.green;
  assign chan[2] = in_pix.blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      linp_nxt[i] = LIN_P_W'(gain) * LIN_P_W'($signed({1'b0, chan[i]}));
    end
    lump_nxt[0] = LUMA_P_W'(LUMA_WR) * LUMA_P_W'(chan[0]);
    lump_nxt[1] = LUMA_P_W'(LUMA_WG) * LUMA_P_W'(chan[1]);
    lump_nxt[2] = LUMA_P_W'(LUMA_WB) * LUMA_P_W'(chan[2]);
  end

  always_comb begin
    logic signed [LIN_S_W-1:0] s;
    logic [LUMA_P_W-1:0]       lsum;
    for (int i = 0; i < 3; i++) begin
      s = LIN_S_W'(linp_r[i]) + LIN_S_W'(offset);
      if (s < 0) begin
        lin_val[i] = '0;
      end else if (s[LIN_S_W-1:CHAN_W] > LIN_S_W'(CHAN_MAX)) begin
        lin_val[i] = CHAN_MAX;
      end else begin
        lin_val[i] = s[2*CHAN_W-1:CHAN_W];
      end
    end
    lsum = lump_r[0] + lump_r[1] + lump_r[2] + LUMA_ROUND;
    side_nxt.lin.red   = lin_val[0];
    side_nxt.lin.green = lin_val[1];
    side_nxt.lin.blue  = lin_val[2];
    side_nxt.luma      = lsum[LUMA_P_W-1:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      linp_r[i] <= linp_nxt[i];
      lump_r[i] <= lump_nxt[i];
    end
    side_r <= side_nxt;
  end

  assign out_valid = v2_r;
  assign out_side  = side_r;

endmodule

### rtl/rpp_quant.sv
module rpp_quant import rpp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [SHADE_W-1:0] shade_count,
  output logic               out_valid,
  output logic [CHAN_W-1:0]  out_post,
  output side_t              out_side
);

  localparam int PROD_W = CHAN_W + SHADE_W;

  function automatic logic [SHADE_W:0] div_step(input logic [SHADE_W-1:0] rem,
                                                input logic [SHADE_W-1:0] d);
    logic [SHADE_W:0] rem2;
    logic [SHADE_W:0] diff;
    rem2 = {rem, 1'b0};
    diff = rem2 - {1'b0, d};
    if (rem2 >= {1'b0, d}) begin
      div_step = {1'b1, diff[SHADE_W-1:0]};
    end else begin
      div_step = {1'b0, rem2[SHADE_W-1:0]};
    end
  endfunction

  logic [PROD_W-1:0]  prod;
  logic               q0_v_r;
  logic [SHADE_W-1:0] q0_q_r;
  logic [SHADE_W-1:0] q0_d_r;
  logic               q0_zero_r;
  side_t              q0_side_r;

  logic               dv_v_r     [DIV_STAGES];
  logic [SHADE_W-1:0] dv_rem_r   [DIV_STAGES];
  logic [SHADE_W-1:0] dv_rem_nxt [DIV_STAGES];
  logic [CHAN_W-1:0]  dv_quo_r   [DIV_STAGES];
  logic [CHAN_W-1:0]  dv_quo_nxt [DIV_STAGES];
  logic [SHADE_W-1:0] dv_d_r     [DIV_STAGES];
  logic [SHADE_W-1:0] dv_d_nxt   [DIV_STAGES];
  logic               dv_zero_r  [DIV_STAGES];
  logic               dv_zero_nxt[DIV_STAGES];
  logic               dv_sat_r   [DIV_STAGES];
  logic               dv_sat_nxt [DIV_STAGES];
  side_t              dv_side_r  [DIV_STAGES];
  side_t              dv_side_nxt[DIV_STAGES];

  assign prod = PROD_W'(in_side.luma) * PROD_W'(shade_count);

  always_ff @(posedge clk) begin
    q0_q_r    <= prod[PROD_W-1:CHAN_W];
    q0_d_r    <= shade_count - SHADE_W'(1);
    q0_zero_r <= (shade_count < SHADE_W'(2));
    q0_side_r <= in_side;
  end

  always_comb begin
    logic [SHADE_W-1:0] rem;
    logic [CHAN_W-1:0]  quo;
    logic [SHADE_W:0]   st;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rem            = q0_q_r;
        quo            = '0;
        dv_d_nxt[k]    = q0_d_r;
        dv_zero_nxt[k] = q0_zero_r;
        dv_sat_nxt[k]  = (q0_q_r >= q0_d_r);
        dv_side_nxt[k] = q0_side_r;
      end else begin
        rem            = dv_rem_r[k-1];
        quo            = dv_quo_r[k-1];
        dv_d_nxt[k]    = dv_d_r[k-1];
        dv_zero_nxt[k] = dv_zero_r[k-1];
        dv_sat_nxt[k]  = dv_sat_r[k-1];
        dv_side_nxt[k] = dv_side_r[k-1];
      end
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        st  = div_step(rem, dv_d_nxt[k]);
        rem = st[SHADE_W-1:0];
        quo = {quo[CHAN_W-2:0], st[SHADE_W]};
      end
      dv_rem_nxt[k] = rem;
      dv_quo_nxt[k] = quo;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv_rem_r[k]  <= dv_rem_nxt[k];
      dv_quo_r[k]  <= dv_quo_nxt[k];
      dv_d_r[k]    <= dv_d_nxt[k];
      dv_zero_r[k] <= dv_zero_nxt[k];
      dv_sat_r[k]  <= dv_sat_nxt[k];
      dv_side_r[k] <= dv_side_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_v_r <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else begin
      q0_v_r    <= in_valid;
      dv_v_r[0] <= q0_v_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end
  end

  always_comb begin
    priority if (dv_zero_r[DIV_STAGES-1]) begin
      out_post = '0;
    end else if (dv_sat_r[DIV_STAGES-1]) begin
      out_post = CHAN_MAX;
    end else begin
      out_post = dv_quo_r[DIV_STAGES-1];
    end
  end

  assign out_valid = dv_v_r[DIV_STAGES-1];
  assign out_side  = dv_side_r[DIV_STAGES-1];

endmodule

### rtl/rgb_pixel_point_operations_top.sv
// Channel  Handshake                  Payload
// input    start, busy                in_red_in, in_green_in, in_blue_in
// output   out_valid (strobe)         out_red_out, out_green_out, out_blue_out
// config   cfg_valid, cfg_ready       cfg_index, cfg_data
//
// One pixel is accepted every cycle; busy is never raised.
// Each result passes through the multiply and sum stages, the shade product stage,
// four stages of the two-bit-per-stage divider and the output register.
// Synchronous active-low reset clears all valid bits and restores register defaults.
// The receiver cannot stall, so results leave the pipeline as they are produced.
module rgb_pixel_point_operations_top import rpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CHAN_W-1:0]     in_red_in,
  input  logic [CHAN_W-1:0]     in_green_in,
  input  logic [CHAN_W-1:0]     in_blue_in,
  output logic                  out_valid,
  output logic [CHAN_W-1:0]     out_red_out,
  output logic [CHAN_W-1:0]     out_green_out,
  output logic [CHAN_W-1:0]     out_blue_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  pix_t              in_pix;
  logic              fr_valid;
  side_t             fr_side;
  logic              qt_valid;
  logic [CHAN_W-1:0] qt_post;
  side_t             qt_side;
  logic              out_valid_r;
  pix_t              out_pix_r;
  pix_t              out_pix_nxt;

  assign busy         = 1'b0;
  assign in_pix.red   = in_red_in;
  assign in_pix.green = in_green_in;
  assign in_pix.blue  = in_blue_in;

  rpp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_pix    (in_pix),
    .gain      (cfg.gain),
    .offset    (cfg.offset),
    .out_valid (fr_valid),
    .out_side  (fr_side)
  );

  rpp_quant u_quant (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (fr_valid),
    .in_side     (fr_side),
    .shade_count (cfg.shade_count),
    .out_valid   (qt_valid),
    .out_post    (qt_post),
    .out_side    (qt_side)
  );

  always_comb begin
    unique case (cfg.mode)
      MODE_LINEAR: out_pix_nxt = qt_side.lin;
      MODE_GRAY:   out_pix_nxt = '{qt_side.luma, qt_side.luma, qt_side.luma};
      MODE_FILL:   out_pix_nxt = '{cfg.fill_level, cfg.fill_level, cfg.fill_level};
      MODE_QUANT:  out_pix_nxt = '{qt_post, qt_post, qt_post};
      default:     out_pix_nxt = qt_side.lin;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= qt_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r.red;
  assign out_green_out = out_pix_r.green;
  assign out_blue_out  = out_pix_r.blue;

endmodule

### rtl/rpp_check.sv
module rpp_check import rpp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result strobe seen right after reset.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("Accepted transaction produced no result at the expected latency.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY))
    else $error("Result strobe without a matching accepted transaction.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("Configuration write was held off.");

endmodule

bind rgb_pixel_point_operations_top rpp_check u_rpp_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
